// ===== sv/scgr_pkg.sv =====
// Shared types, constants and helpers of the span-coded glyph rasterizer.
package scgr_pkg;

    localparam int MAX_GLYPHS       = 128;
    localparam int LINE_TABLE_DEPTH = 4096;
    localparam int SPAN_TABLE_DEPTH = 16384;
    localparam int BITMAP_WIDTH     = 1024;
    localparam int BITMAP_HEIGHT    = 64;

    localparam int GLYPH_AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int LINE_AW  = $clog2(LINE_TABLE_DEPTH);
    localparam int SPAN_AW  = $clog2(SPAN_TABLE_DEPTH);

    // Bitmap is kept as 64-bit words, packed row after row.
    localparam int BM_WORD_W = 64;
    localparam int BM_POS_W  = 6;
    localparam int BM_BITS   = BITMAP_WIDTH * BITMAP_HEIGHT;
    localparam int BM_WORDS  = (BM_BITS + BM_WORD_W - 1) / BM_WORD_W;
    localparam int BM_WAW    = $clog2(BM_WORDS);
    localparam int BM_BIT_W  = $clog2(BM_BITS);

    localparam int PEN_W = 10;
    localparam logic [PEN_W-1:0] PEN_MAX = 10'd1023;

    localparam logic [2:0] ACT_BEGIN      = 3'd0;
    localparam logic [2:0] ACT_LOAD_GLYPH = 3'd1;
    localparam logic [2:0] ACT_LOAD_LINE  = 3'd2;
    localparam logic [2:0] ACT_LOAD_SPAN  = 3'd3;
    localparam logic [2:0] ACT_DRAW       = 3'd4;
    localparam logic [2:0] ACT_READ       = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_CLIPPED = 2'd2;

    localparam logic [3:0] CFG_FIRST_CHAR = 4'd0;
    localparam logic [3:0] CFG_GLYPH_CNT  = 4'd1;
    localparam logic [3:0] CFG_LEFT_LAP   = 4'd2;
    localparam logic [3:0] CFG_RIGHT_LAP  = 4'd3;
    localparam logic [3:0] CFG_ASCENT     = 4'd4;
    localparam logic [3:0] CFG_DESCENT    = 4'd5;
    localparam logic [3:0] CFG_BACK_COLOR = 4'd6;
    localparam logic [3:0] CFG_INK_COLOR  = 4'd7;

    typedef enum logic [2:0] {
        CMD_BEGIN,
        CMD_GLYPH,
        CMD_LINE,
        CMD_SPAN,
        CMD_DRAW,
        CMD_READ,
        CMD_IGNORE
    } cmd_kind_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [13:0]       item_index;
        logic [7:0]        table_byte;
        logic [5:0]        pixel_row;
        logic [7:0]        glyph_width;
        logic [4:0]        glyph_ascent;
        logic [4:0]        glyph_descent;
        logic signed [7:0] glyph_shift;
        logic [11:0]       line_table_start;
        logic [13:0]       span_table_start;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] pixel_color;
        logic [9:0]  pen_position;
        logic [10:0] string_width;
        logic [11:0] texture_width;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  first_char_code;
        logic [7:0]  glyph_count;
        logic [7:0]  left_overlap;
        logic [7:0]  right_overlap;
        logic [4:0]  font_ascent;
        logic [4:0]  font_descent;
        logic [31:0] back_color;
        logic [31:0] ink_color;
    } cfg_t;

    typedef struct packed {
        logic [7:0]        width;
        logic [4:0]        ascent;
        logic [4:0]        descent;
        logic signed [7:0] shift;
        logic [11:0]       line_start;
        logic [13:0]       span_start;
    } glyph_t;

    localparam int GLYPH_W = $bits(glyph_t);

    typedef struct packed {
        cmd_kind_t kind;
        in_item_t  item;
    } cmd_t;

    // Smallest power of two not below sw (sw is at least one).
    function automatic logic [11:0] texture_of(input logic [10:0] sw);
        logic [10:0] m;
        logic [11:0] tw;
        m  = sw - 11'd1;
        tw = 12'd1;
        for (int i = 0; i < 11; i++) begin
            if (m[i]) begin
                tw = 12'd2 << i;
            end
        end
        return tw;
    endfunction

endpackage

// ===== sv/scgr_ram.sv =====
// Generic single-port RAM with registered read data.
module scgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/scgr_front.sv =====
// Front end: classify input beats and hold them in a two-entry command queue.
module scgr_front
    import scgr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);

    cmd_t        q_reg [2];
    logic        wr_reg, wr_next;
    logic        rd_reg, rd_next;
    logic [1:0]  cnt_reg, cnt_next;
    cmd_t        cls;
    logic [13:0] diff;
    logic        do_push;

    always_comb
    begin
        cls      = '{kind: CMD_IGNORE, item: item};
        diff     = item.item_index - 14'(cfg.first_char_code);
        case (item.action)
            ACT_BEGIN:      cls.kind = CMD_BEGIN;
            ACT_LOAD_GLYPH: if (item.item_index < MAX_GLYPHS) cls.kind = CMD_GLYPH;
            ACT_LOAD_LINE:  if (item.item_index < LINE_TABLE_DEPTH) cls.kind = CMD_LINE;
            ACT_LOAD_SPAN:  if (item.item_index < SPAN_TABLE_DEPTH) cls.kind = CMD_SPAN;
            ACT_DRAW:
            begin
                // Map the code to its glyph index.
                if (item.item_index >= 14'(cfg.first_char_code) &&
                    diff < 14'(cfg.glyph_count) && diff < MAX_GLYPHS)
                begin
                    cls.kind            = CMD_DRAW;
                    cls.item.item_index = diff;
                end
            end
            ACT_READ:
            begin
                if (item.item_index < BITMAP_WIDTH && item.pixel_row < BITMAP_HEIGHT)
                begin
                    cls.kind = CMD_READ;
                end
            end
            default: cls.kind = CMD_IGNORE;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign do_push   = push && !full;

    always_comb
    begin
        wr_next  = do_push ? !wr_reg : wr_reg;
        rd_next  = cmd_pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= cls;
        end
    end

endmodule

// ===== sv/scgr_resq.sv =====
// Two-entry result queue in front of the result ports.
module scgr_resq
    import scgr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_push,
    input  out_item_t res,
    output logic      res_full,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    out_item_t  q_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       do_pop;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign result   = q_reg[rd_reg];
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (res_push) wr_reg <= !wr_reg;
            if (do_pop)   rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, res_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_reg] <= res;
        end
    end

endmodule

// ===== sv/scgr_back.sv =====
// Back end: table loads, glyph span walk, bitmap clear and pixel reads.
module scgr_back
    import scgr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    input  logic      res_full,
    output logic      res_push,
    output out_item_t res
);

    localparam int XW  = 16;
    localparam int YW  = 10;
    localparam int LPW = ((LINE_AW > 12) ? LINE_AW : 12) + 1;
    localparam int SPW = ((SPAN_AW > 14) ? SPAN_AW : 14) + 1;

    typedef enum logic [3:0] {
        CLEAR_INIT, CLEAR, IDLE, RD_WAIT, G_WAIT, NORM, ROW, ROW_WAIT,
        SPAN, SPAN_WAIT, TEXEL, INK_WR, DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [PEN_W-1:0]      pen_reg, pen_next;
    logic                  clipped_reg, clipped_next;
    logic [1:0]            status_reg, status_next;
    logic [31:0]           color_reg, color_next;
    logic [BM_WAW-1:0]     clr_reg, clr_next;
    glyph_t                glyph_reg, glyph_next;
    logic signed [YW-1:0]  y_reg, y_next, top_reg, top_next;
    logic [LPW-1:0]        lp_reg, lp_next;
    logic [SPW-1:0]        sp_reg, sp_next;
    logic signed [XW-1:0]  x_reg, x_next;
    logic [7:0]            cnt_reg, cnt_next;
    logic [2:0]            run_reg, run_next;
    logic [BM_WAW-1:0]     ink_addr_reg, ink_addr_next;
    logic [BM_POS_W-1:0]   ink_pos_reg, ink_pos_next;

    logic                  gl_we, ln_we, sp_we, bm_we;
    logic [GLYPH_AW-1:0]   gl_addr;
    logic [LINE_AW-1:0]    ln_addr;
    logic [SPAN_AW-1:0]    sp_addr;
    logic [BM_WAW-1:0]     bm_addr;
    logic [GLYPH_W-1:0]    gl_wdata, gl_rdata;
    logic [7:0]            ln_rdata, sp_rdata;
    logic [BM_WORD_W-1:0]  bm_wdata, bm_rdata;

    glyph_t                g_in, g_rd;
    logic [BM_BIT_W-1:0]   pix_bit, ink_bit;
    logic [10:0]           pen_sum;
    logic [6:0]            height;
    logic signed [YW-1:0]  row_lim;
    logic                  in_range;

    scgr_ram #(.WIDTH(GLYPH_W), .DEPTH(MAX_GLYPHS)) u_glyph_ram (
        .clk(clk), .we(gl_we), .addr(gl_addr), .wdata(gl_wdata), .rdata(gl_rdata)
    );
    scgr_ram #(.WIDTH(8), .DEPTH(LINE_TABLE_DEPTH)) u_line_ram (
        .clk(clk), .we(ln_we), .addr(ln_addr), .wdata(cmd.item.table_byte),
        .rdata(ln_rdata)
    );
    scgr_ram #(.WIDTH(8), .DEPTH(SPAN_TABLE_DEPTH)) u_span_ram (
        .clk(clk), .we(sp_we), .addr(sp_addr), .wdata(cmd.item.table_byte),
        .rdata(sp_rdata)
    );
    scgr_ram #(.WIDTH(BM_WORD_W), .DEPTH(BM_WORDS)) u_bitmap_ram (
        .clk(clk), .we(bm_we), .addr(bm_addr), .wdata(bm_wdata), .rdata(bm_rdata)
    );

    always_comb
    begin
        g_in.width      = cmd.item.glyph_width;
        g_in.ascent     = cmd.item.glyph_ascent;
        g_in.descent    = cmd.item.glyph_descent;
        g_in.shift      = cmd.item.glyph_shift;
        g_in.line_start = cmd.item.line_table_start;
        g_in.span_start = cmd.item.span_table_start;
        g_rd            = glyph_t'(gl_rdata);
        pix_bit  = BM_BIT_W'(cmd.item.pixel_row) * BM_BIT_W'(BITMAP_WIDTH) +
                   BM_BIT_W'(cmd.item.item_index);
        ink_bit  = BM_BIT_W'(y_reg) * BM_BIT_W'(BITMAP_WIDTH) + BM_BIT_W'(x_reg);
        pen_sum  = {1'b0, pen_reg} + {3'b000, glyph_reg.width};
        height   = 7'(cfg.font_ascent) + 7'(cfg.font_descent) + 7'd2;
        row_lim  = (height < BITMAP_HEIGHT) ? YW'(height) : YW'(BITMAP_HEIGHT);
        in_range = (x_reg >= 0) && (x_reg < XW'(BITMAP_WIDTH)) &&
                   (y_reg >= 0) && (y_reg < row_lim);
    end

    always_comb
    begin
        state_next    = state_reg;
        pen_next      = pen_reg;
        clipped_next  = clipped_reg;
        status_next   = status_reg;
        color_next    = color_reg;
        clr_next      = clr_reg;
        glyph_next    = glyph_reg;
        y_next        = y_reg;
        top_next      = top_reg;
        lp_next       = lp_reg;
        sp_next       = sp_reg;
        x_next        = x_reg;
        cnt_next      = cnt_reg;
        run_next      = run_reg;
        ink_addr_next = ink_addr_reg;
        ink_pos_next  = ink_pos_reg;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        gl_we         = 1'b0;
        ln_we         = 1'b0;
        sp_we         = 1'b0;
        bm_we         = 1'b0;
        gl_addr       = GLYPH_AW'(cmd.item.item_index);
        ln_addr       = LINE_AW'(lp_reg);
        sp_addr       = SPAN_AW'(sp_reg);
        bm_addr       = ink_addr_reg;
        gl_wdata      = g_in;
        bm_wdata      = '0;
        case (state_reg)
            CLEAR_INIT, CLEAR:
            begin
                bm_we   = 1'b1;
                bm_addr = clr_reg;
                if (clr_reg == BM_WAW'(BM_WORDS - 1))
                begin
                    clr_next   = '0;
                    state_next = (state_reg == CLEAR) ? DONE : IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    status_next  = ST_OK;
                    color_next   = '0;
                    clipped_next = 1'b0;
                    state_next   = DONE;
                    case (cmd.kind)
                        CMD_BEGIN:
                        begin
                            pen_next   = PEN_W'({1'b0, cfg.left_overlap} + 9'd1);
                            state_next = CLEAR;
                        end
                        CMD_GLYPH: gl_we = 1'b1;
                        CMD_LINE:
                        begin
                            ln_we   = 1'b1;
                            ln_addr = LINE_AW'(cmd.item.item_index);
                        end
                        CMD_SPAN:
                        begin
                            sp_we   = 1'b1;
                            sp_addr = SPAN_AW'(cmd.item.item_index);
                        end
                        CMD_DRAW: state_next = G_WAIT;
                        CMD_READ:
                        begin
                            bm_addr      = BM_WAW'(pix_bit >> BM_POS_W);
                            ink_pos_next = pix_bit[BM_POS_W-1:0];
                            state_next   = RD_WAIT;
                        end
                        default: status_next = ST_IGNORED;
                    endcase
                end
            end
            RD_WAIT:
            begin
                color_next = bm_rdata[ink_pos_reg] ? cfg.ink_color : cfg.back_color;
                state_next = DONE;
            end
            G_WAIT:
            begin
                glyph_next = g_rd;
                y_next     = YW'(cfg.font_descent) + YW'(1) - YW'(g_rd.descent);
                top_next   = YW'(cfg.font_descent) + YW'(1) + YW'(g_rd.ascent);
                lp_next    = LPW'(g_rd.line_start);
                sp_next    = SPW'(g_rd.span_start);
                state_next = NORM;
            end
            NORM:
            begin
                // Fold start addresses into the table depth.
                if (lp_reg >= LPW'(LINE_TABLE_DEPTH))
                begin
                    lp_next = lp_reg - LPW'(LINE_TABLE_DEPTH);
                end
                if (sp_reg >= SPW'(SPAN_TABLE_DEPTH))
                begin
                    sp_next = sp_reg - SPW'(SPAN_TABLE_DEPTH);
                end
                if (lp_reg < LPW'(LINE_TABLE_DEPTH) && sp_reg < SPW'(SPAN_TABLE_DEPTH))
                begin
                    state_next = ROW;
                end
            end
            ROW:
            begin
                if (y_reg >= top_reg)
                begin
                    pen_next    = (pen_sum > 11'(PEN_MAX)) ? PEN_MAX : pen_sum[PEN_W-1:0];
                    status_next = clipped_reg ? ST_CLIPPED : ST_OK;
                    state_next  = DONE;
                end
                else
                begin
                    lp_next    = (lp_reg == LPW'(LINE_TABLE_DEPTH - 1)) ? '0 : lp_reg + 1'b1;
                    x_next     = XW'({1'b0, pen_reg}) + XW'(signed'(glyph_reg.shift));
                    state_next = ROW_WAIT;
                end
            end
            ROW_WAIT:
            begin
                cnt_next   = ln_rdata;
                state_next = SPAN;
            end
            SPAN:
            begin
                if (cnt_reg == 8'd0)
                begin
                    y_next     = y_reg + YW'(1);
                    state_next = ROW;
                end
                else
                begin
                    sp_next    = (sp_reg == SPW'(SPAN_TABLE_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
                    cnt_next   = cnt_reg - 8'd1;
                    state_next = SPAN_WAIT;
                end
            end
            SPAN_WAIT:
            begin
                x_next     = x_reg + XW'(sp_rdata[7:3]);
                run_next   = sp_rdata[2:0];
                state_next = TEXEL;
            end
            TEXEL:
            begin
                if (run_reg == 3'd0)
                begin
                    state_next = SPAN;
                end
                else if (in_range)
                begin
                    bm_addr       = BM_WAW'(ink_bit >> BM_POS_W);
                    ink_addr_next = BM_WAW'(ink_bit >> BM_POS_W);
                    ink_pos_next  = ink_bit[BM_POS_W-1:0];
                    state_next    = INK_WR;
                end
                else
                begin
                    clipped_next = 1'b1;
                    x_next       = x_reg + XW'(1);
                    run_next     = run_reg - 3'd1;
                end
            end
            INK_WR:
            begin
                bm_we      = 1'b1;
                bm_wdata   = bm_rdata | (BM_WORD_W'(1) << ink_pos_reg);
                x_next     = x_reg + XW'(1);
                run_next   = run_reg - 3'd1;
                state_next = TEXEL;
            end
            DONE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_comb
    begin
        res.status        = status_reg;
        res.pixel_color   = color_reg;
        res.pen_position  = pen_reg;
        res.string_width  = {1'b0, pen_reg} + {3'b000, cfg.right_overlap} + 11'd1;
        res.texture_width = texture_of(res.string_width);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= CLEAR_INIT;
            pen_reg     <= '0;
            clipped_reg <= 1'b0;
            status_reg  <= ST_OK;
            clr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pen_reg     <= pen_next;
            clipped_reg <= clipped_next;
            status_reg  <= status_next;
            clr_reg     <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg    <= color_next;
        glyph_reg    <= glyph_next;
        y_reg        <= y_next;
        top_reg      <= top_next;
        lp_reg       <= lp_next;
        sp_reg       <= sp_next;
        x_reg        <= x_next;
        cnt_reg      <= cnt_next;
        run_reg      <= run_next;
        ink_addr_reg <= ink_addr_next;
        ink_pos_reg  <= ink_pos_next;
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == IDLE) && cmd_valid)
        else $error("command taken outside idle");

    a_ink_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == INK_WR) |-> ($past(state_reg) == TEXEL))
        else $error("ink write without a preceding word read");

    a_clear_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CLEAR) && (state_next != CLEAR) |=> (state_reg == DONE))
        else $error("begin sweep did not report");

endmodule

// ===== sv/span_coded_glyph_rasterizer.sv =====
// Top level of the span-coded glyph rasterizer: config registers and the two halves.
// A load, an ignored beat or a pixel read passes the command queue, the back end and
// the result queue. A draw is set by the span walk of the back end, one span RAM read
// at a time, over each glyph row, each span and each clipped or drawn texel.
// A begin sweeps the bitmap RAM, one 64-bit word a cycle, over all BM_WORDS (1024) words.
// Reset (rst_n low, asynchronous) empties both queues and starts the same sweep;
// input beats are queued but not executed until it ends. Tables are undefined until loaded.
module span_coded_glyph_rasterizer
    import scgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_pop;
    logic      res_full;
    logic      res_push;
    out_item_t res;

    // Config writes are always taken; software writes only while the block is idle (not enforced here).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{first_char_code: 8'd0,
                         glyph_count:     8'd0,
                         left_overlap:    8'd0,
                         right_overlap:   8'd0,
                         font_ascent:     5'd0,
                         font_descent:    5'd0,
                         back_color:      32'hFFFF_FFFF,
                         ink_color:       32'd0};
        end
        else if (cfg_valid)
        begin
            // Drop writes to indexes past the register list.
            case (cfg_index)
                CFG_FIRST_CHAR: cfg_reg.first_char_code <= cfg_data[7:0];
                CFG_GLYPH_CNT:  cfg_reg.glyph_count     <= cfg_data[7:0];
                CFG_LEFT_LAP:   cfg_reg.left_overlap    <= cfg_data[7:0];
                CFG_RIGHT_LAP:  cfg_reg.right_overlap   <= cfg_data[7:0];
                CFG_ASCENT:     cfg_reg.font_ascent     <= cfg_data[4:0];
                CFG_DESCENT:    cfg_reg.font_descent    <= cfg_data[4:0];
                CFG_BACK_COLOR: cfg_reg.back_color      <= cfg_data;
                CFG_INK_COLOR:  cfg_reg.ink_color       <= cfg_data;
                default:        cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Front: classify each input beat and hold it until the back end is free.
    scgr_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .push(push), .full(full), .item(item),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
    );

    // Back: run one command at a time against the tables and the bitmap.
    scgr_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
        .res_full(res_full), .res_push(res_push), .res(res)
    );

    // Results wait here so the back end can start the next command.
    scgr_resq u_resq (
        .clk(clk), .rst_n(rst_n),
        .res_push(res_push), .res(res), .res_full(res_full),
        .empty(empty), .pop(pop), .result(result)
    );

endmodule
